@@ src/skt_pkg.sv @@
// Shared types and constants for the sorted key table.
// Operation and status codes, controller/datapath command and status structs.
// No dependencies.
package skt_pkg;

   localparam int DEPTH_DEF = 128;

   localparam int KEY_W   = 32;
   localparam int PAY_W   = 32;
   localparam int COUNT_W = 8;

   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_REMOVE = 2'd1,
      OP_LOOKUP = 2'd2,
      OP_NONE   = 2'd3
   } op_type;

   localparam logic [1:0] STAT_OK      = 2'd0;
   localparam logic [1:0] STAT_FULL    = 2'd1;
   localparam logic [1:0] STAT_EMPTY   = 2'd2;
   localparam logic [1:0] STAT_MISSING = 2'd3;

   typedef enum logic [1:0] {
      RD_IDX  = 2'd0,
      RD_PREV = 2'd1,
      RD_NEXT = 2'd2
   } rd_src_type;

   typedef struct packed {
      logic       load;
      logic       rd_en;
      rd_src_type rd_src;
      logic       idx_inc;
      logic       ptr_load;
      logic       ptr_step;
      logic       wr_shift;
      logic       wr_place;
      logic       take_found;
      logic       set_status;
      logic [1:0] status_code;
      logic       count_inc;
      logic       count_dec;
      logic       respond;
   } cmd_type;

   typedef struct packed {
      logic is_insert;
      logic is_remove;
      logic is_lookup;
      logic full;
      logic empty;
      logic idx_end;
      logic key_greater;
      logic key_equal;
      logic shift_done;
      logic out_free;
   } stat_type;

endpackage

@@ src/skt_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module skt_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ src/skt_datapath.sv @@
// Datapath of the sorted key table: request registers, entry count, search and
// shift pointers, record RAM and result register.
// Depends on skt_pkg and skt_ram.
module skt_datapath import skt_pkg::*; #(
   parameter int DEPTH = DEPTH_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic [1:0]                req_op,
   input  logic signed [KEY_W-1:0]   req_key,
   input  logic [PAY_W-1:0]          req_payload,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [1:0]                rsp_status,
   output logic [PAY_W-1:0]          rsp_found_payload,
   output logic [COUNT_W-1:0]        rsp_count,
   input  cmd_type                   cmd,
   output stat_type                  st
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int RW = KEY_W + PAY_W;

   op_type             op_ff;
   logic [KEY_W-1:0]   key_ff;
   logic [PAY_W-1:0]   pay_ff;
   logic [CW-1:0]      count_ff, count_in;
   logic [CW-1:0]      idx_ff, idx_in;
   logic [CW-1:0]      ptr_ff, ptr_in;
   logic [1:0]         status_ff;
   logic [PAY_W-1:0]   found_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [1:0]         rsp_status_ff;
   logic [PAY_W-1:0]   rsp_found_ff;
   logic [COUNT_W-1:0] rsp_count_ff;

   logic [CW-1:0]      ptr_p1;
   logic [CW-1:0]      ptr_m1;
   logic [AW-1:0]      rd_addr;
   logic [AW-1:0]      wr_addr;
   logic [RW-1:0]      wr_data;
   logic [RW-1:0]      rd_data;
   logic [KEY_W-1:0]   rd_key;

   assign ptr_p1 = ptr_ff + 1'b1;
   assign ptr_m1 = ptr_ff - 1'b1;
   assign rd_key = rd_data[RW-1:PAY_W];

   always_comb begin
      unique case (cmd.rd_src)
         RD_IDX:  rd_addr = idx_ff[AW-1:0];
         RD_PREV: rd_addr = ptr_m1[AW-1:0];
         RD_NEXT: rd_addr = ptr_p1[AW-1:0];
         default: rd_addr = idx_ff[AW-1:0];
      endcase
   end

   assign wr_addr = cmd.wr_shift ? ptr_ff[AW-1:0] : idx_ff[AW-1:0];
   assign wr_data = cmd.wr_shift ? rd_data : {key_ff, pay_ff};

   skt_ram #(
      .WIDTH (RW),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (cmd.wr_shift | cmd.wr_place),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (cmd.rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      st.is_insert   = (op_ff == OP_INSERT);
      st.is_remove   = (op_ff == OP_REMOVE);
      st.is_lookup   = (op_ff == OP_LOOKUP);
      st.full        = (count_ff == CW'(DEPTH));
      st.empty       = (count_ff == '0);
      st.idx_end     = (idx_ff == count_ff);
      st.key_greater = ($signed(key_ff) > $signed(rd_key));
      st.key_equal   = (key_ff == rd_key);
      st.shift_done  = (op_ff == OP_INSERT) ? (ptr_ff == idx_ff) : (ptr_p1 >= count_ff);
      st.out_free    = !rsp_valid_ff || !rsp_stall;
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.count_inc) begin
         count_in = count_ff + 1'b1;
      end else if (cmd.count_dec) begin
         count_in = count_ff - 1'b1;
      end

      idx_in = idx_ff;
      if (cmd.load) begin
         idx_in = '0;
      end else if (cmd.idx_inc) begin
         idx_in = idx_ff + 1'b1;
      end

      ptr_in = ptr_ff;
      if (cmd.ptr_load) begin
         ptr_in = (op_ff == OP_INSERT) ? count_ff : idx_ff;
      end else if (cmd.ptr_step) begin
         ptr_in = (op_ff == OP_INSERT) ? ptr_m1 : ptr_p1;
      end

      rsp_valid_in = rsp_valid_ff;
      if (cmd.respond) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         idx_ff       <= '0;
         ptr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         idx_ff       <= idx_in;
         ptr_ff       <= ptr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff     <= op_type'(req_op);
         key_ff    <= req_key;
         pay_ff    <= req_payload;
         status_ff <= STAT_OK;
         found_ff  <= '0;
      end else begin
         if (cmd.set_status) begin
            status_ff <= cmd.status_code;
         end
         if (cmd.take_found) begin
            found_ff <= rd_data[PAY_W-1:0];
         end
      end
      if (cmd.respond) begin
         rsp_status_ff <= status_ff;
         rsp_found_ff  <= found_ff;
         rsp_count_ff  <= COUNT_W'(count_ff);
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_found_payload = rsp_found_ff;
   assign rsp_count         = rsp_count_ff;

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("entry count beyond capacity");

   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      idx_ff <= count_ff && ptr_ff <= count_ff)
      else $error("search or shift pointer beyond entry count");

   a_no_overfill: assert property (@(posedge clock) disable iff (reset)
      cmd.count_inc |-> !st.full && st.is_insert)
      else $error("insert on full table");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      cmd.count_dec |-> !st.empty && st.is_remove)
      else $error("remove on empty table");

   a_respond_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.respond |-> st.out_free ##1 rsp_valid_ff)
      else $error("result register overwritten or lost");

endmodule

@@ src/skt_ctrl.sv @@
// Controller of the sorted key table: sequences decode, linear search,
// entry shift, record placement and result transfer.
// Depends on skt_pkg.
module skt_ctrl import skt_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_stall,
   input  stat_type st,
   output cmd_type  cmd
);

   typedef enum logic [7:0] {
      S_IDLE     = 8'b0000_0001,
      S_DECIDE   = 8'b0000_0010,
      S_SRCH_RD  = 8'b0000_0100,
      S_SRCH_CMP = 8'b0000_1000,
      S_SHIFT_RD = 8'b0001_0000,
      S_SHIFT_WR = 8'b0010_0000,
      S_PLACE    = 8'b0100_0000,
      S_RESPOND  = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      cmd       = '0;
      state_in  = state_ff;
      req_stall = 1'b1;
      unique case (state_ff)
         S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            priority if (st.is_insert && st.full) begin
               cmd.set_status  = 1'b1;
               cmd.status_code = STAT_FULL;
               state_in        = S_RESPOND;
            end else if (st.is_remove && st.empty) begin
               cmd.set_status  = 1'b1;
               cmd.status_code = STAT_EMPTY;
               state_in        = S_RESPOND;
            end else if (!st.is_insert && !st.is_remove && !st.is_lookup) begin
               state_in = S_RESPOND;
            end else begin
               state_in = S_SRCH_RD;
            end
         end
         S_SRCH_RD: begin
            if (st.idx_end) begin
               if (st.is_insert) begin
                  cmd.ptr_load = 1'b1;
                  state_in     = S_SHIFT_RD;
               end else begin
                  cmd.set_status  = 1'b1;
                  cmd.status_code = STAT_MISSING;
                  state_in        = S_RESPOND;
               end
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.rd_src = RD_IDX;
               state_in   = S_SRCH_CMP;
            end
         end
         S_SRCH_CMP: begin
            priority if (st.key_greater) begin
               cmd.idx_inc = 1'b1;
               state_in    = S_SRCH_RD;
            end else if (st.is_insert) begin
               cmd.ptr_load = 1'b1;
               state_in     = S_SHIFT_RD;
            end else if (st.key_equal) begin
               cmd.take_found = 1'b1;
               if (st.is_remove) begin
                  cmd.ptr_load = 1'b1;
                  state_in     = S_SHIFT_RD;
               end else begin
                  state_in = S_RESPOND;
               end
            end else begin
               cmd.set_status  = 1'b1;
               cmd.status_code = STAT_MISSING;
               state_in        = S_RESPOND;
            end
         end
         S_SHIFT_RD: begin
            if (st.shift_done) begin
               if (st.is_insert) begin
                  state_in = S_PLACE;
               end else begin
                  cmd.count_dec = 1'b1;
                  state_in      = S_RESPOND;
               end
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.rd_src = st.is_insert ? RD_PREV : RD_NEXT;
               state_in   = S_SHIFT_WR;
            end
         end
         S_SHIFT_WR: begin
            cmd.wr_shift = 1'b1;
            cmd.ptr_step = 1'b1;
            state_in     = S_SHIFT_RD;
         end
         S_PLACE: begin
            cmd.wr_place  = 1'b1;
            cmd.count_inc = 1'b1;
            state_in      = S_RESPOND;
         end
         S_RESPOND: begin
            if (st.out_free) begin
               cmd.respond = 1'b1;
               state_in    = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ src/sorted_key_table_top.sv @@
// Sorted key table: one request in flight. Each search step reads one entry from the registered
// RAM and compares its key; each shift step reads one entry and writes it one place along. A new
// request is taken once the result has gone to the output register and the controller is idle.
// A finished result waits in an output register; a stalled one holds the next in its respond step.
// Reset clears the entry count and the result valid; the RAM is not cleared.
// Depends on skt_pkg, skt_ctrl, skt_datapath and skt_ram.
module sorted_key_table_top import skt_pkg::*; #(
   parameter int DEPTH = DEPTH_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [1:0]              req_op,
   input  logic signed [KEY_W-1:0] req_key,
   input  logic [PAY_W-1:0]        req_payload,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [1:0]              rsp_status,
   output logic [PAY_W-1:0]        rsp_found_payload,
   output logic [COUNT_W-1:0]      rsp_count
);

   cmd_type  cmd;
   stat_type st;

   skt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .st        (st),
      .cmd       (cmd)
   );

   skt_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .req_op            (req_op),
      .req_key           (req_key),
      .req_payload       (req_payload),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_found_payload (rsp_found_payload),
      .rsp_count         (rsp_count),
      .cmd               (cmd),
      .st                (st)
   );

endmodule
